@@ src/rfid_dedup_pkg.sv @@
`default_nettype none

package rfid_dedup_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int EPC_BYTES   = 12;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;

  localparam logic [7:0] SOF_FIRST  = 8'hA5;
  localparam logic [7:0] SOF_SECOND = 8'h5A;

  localparam logic [1:0] STATUS_UPDATED   = 2'd0;
  localparam logic [1:0] STATUS_ADDED     = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_MALFORMED = 2'd3;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic [EPC_BYTES-1:0][7:0] epc_t;

  // One table row: the tag's EPC, its best RSSI and its sighting count.
  typedef struct packed {
    epc_t               epc;
    logic signed [15:0] rssi;
    logic [15:0]        cnt;
  } row_t;

  // Result beat layout, highest bits first, so status lands in the lowest bits.
  typedef struct packed {
    logic [IDX_W-1:0]   best_slot;
    logic [CNT_W-1:0]   entries;
    logic signed [15:0] tag_rssi;
    logic [15:0]        tag_count;
    logic [IDX_W-1:0]   slot;
    logic [1:0]         status;
  } result_t;

endpackage

`default_nettype wire

@@ src/rfid_tag_inventory_dedup.sv @@
`default_nettype none

// Inventory de-duplicator for a UHF reader byte stream. Each input beat carries one
// received byte (tuser low) or a clear command (tuser high) that empties the tag table
// and restarts the frame parser. The parser looks for the A5 5A start pair, a 16-bit
// big-endian frame length, the PC word, the EPC and a signed RSSI in tenths of dBm.
// Every finished frame gives one result beat: whether the tag was updated, added,
// dropped for lack of room or malformed, its slot, count and best RSSI, the number of
// entries and the best entry (most sightings, then highest RSSI, then lowest index).
// A byte that does not end a frame leaves the block ready for the next beat. A frame
// end is checked, looked up if well formed, then reported, and may wait while an earlier
// result is still held at the output: the table lives in one memory with a single
// read port, and the lookup scans the occupied rows one per cycle. A new beat is
// taken while an earlier result still waits at the output. The table is not cleared
// on reset or on the clear command; only rows below the entry count are ever compared.
module rfid_tag_inventory_dedup (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // status, slot, tag_count, tag_rssi, entries,
                                      // best_slot, zero fill
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata  // capacity
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIN  = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;

  localparam logic [2:0] PH_SOF1 = 3'd0;
  localparam logic [2:0] PH_SOF2 = 3'd1;
  localparam logic [2:0] PH_LENH = 3'd2;
  localparam logic [2:0] PH_LENL = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;

  localparam logic [6:0] DEPTH7 = 7'(rfid_dedup_pkg::TABLE_DEPTH);

  logic [2:0]  state;
  logic [2:0]  phase;
  logic [15:0] pos;
  logic [15:0] flen;
  logic [15:0] pc;
  logic [15:0] frame_rssi;
  rfid_dedup_pkg::epc_t epc_buf;
  logic [6:0]  capacity;
  logic [6:0]  entry_count;
  logic [5:0]  best_entry;
  logic [15:0] best_cnt;
  logic signed [15:0] best_rssi;

  logic [6:0]  rd_idx;
  logic        cmp_vld;
  logic [5:0]  cmp_idx;

  logic [1:0]  res_status;
  logic [5:0]  res_slot;
  logic [15:0] res_cnt;
  logic [15:0] res_rssi;

  // Tag table: one row per entry, one read and one write port.
  rfid_dedup_pkg::row_t mem [rfid_dedup_pkg::TABLE_DEPTH];
  rfid_dedup_pkg::row_t rd_data;
  rfid_dedup_pkg::row_t wr_data;
  logic        mem_we;
  logic [5:0]  wr_addr;

  logic        hit;
  logic        miss_done;
  logic        add_ok;
  logic [6:0]  limit;
  logic [15:0] new_cnt;
  logic signed [15:0] new_rssi;
  logic [5:0]  cand_idx;
  logic        better;
  logic [5:0]  elen;
  logic [15:0] off;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    limit     = (capacity > DEPTH7) ? DEPTH7 : capacity;
    add_ok    = entry_count < limit;
    hit       = (state == ST_SRCH) && cmp_vld && (rd_data.epc == epc_buf);
    miss_done = (state == ST_SRCH) && !cmp_vld && (rd_idx >= entry_count);
    elen      = {pc[15:11], 1'b0};
    off       = pos - 16'd7;
    if (hit) begin
      new_cnt  = (rd_data.cnt == 16'hFFFF) ? rd_data.cnt : rd_data.cnt + 16'd1;
      new_rssi = ($signed(frame_rssi) > rd_data.rssi) ? $signed(frame_rssi) : rd_data.rssi;
      cand_idx = cmp_idx;
      wr_data  = '{epc: rd_data.epc, rssi: new_rssi, cnt: new_cnt};
    end else begin
      new_cnt  = 16'd1;
      new_rssi = $signed(frame_rssi);
      cand_idx = entry_count[5:0];
      wr_data  = '{epc: epc_buf, rssi: new_rssi, cnt: new_cnt};
    end
    wr_addr = cand_idx;
    mem_we  = hit || (miss_done && add_ok);
    // Only the touched entry's key grows, so it either overtakes the best or not.
    better  = (entry_count == 7'd0) || (new_cnt > best_cnt) ||
              ((new_cnt == best_cnt) && ((new_rssi > best_rssi) ||
               ((new_rssi == best_rssi) && (cand_idx < best_entry))));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_idx[5:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_SOF1;
      pos         <= '0;
      flen        <= '0;
      pc          <= '0;
      frame_rssi  <= '0;
      epc_buf     <= '0;
      capacity    <= DEPTH7;
      entry_count <= '0;
      best_entry  <= '0;
      best_cnt    <= '0;
      best_rssi   <= '0;
      rd_idx      <= '0;
      cmp_vld     <= 1'b0;
      cmp_idx     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      // A finished result replaces the held one as soon as that one is taken.
      if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser != rfid_dedup_pkg::OP_BYTE) begin
              phase       <= PH_SOF1;
              pos         <= '0;
              flen        <= '0;
              pc          <= '0;
              frame_rssi  <= '0;
              epc_buf     <= '0;
              entry_count <= '0;
              best_entry  <= '0;
              best_cnt    <= '0;
              best_rssi   <= '0;
            end else begin
              unique case (phase)
                PH_SOF1: begin
                  if (s_tdata == rfid_dedup_pkg::SOF_FIRST) begin
                    phase <= PH_SOF2;
                  end
                end
                PH_SOF2: begin
                  if (s_tdata == rfid_dedup_pkg::SOF_SECOND) begin
                    phase <= PH_LENH;
                  end else if (s_tdata != rfid_dedup_pkg::SOF_FIRST) begin
                    phase <= PH_SOF1;
                  end
                end
                PH_LENH: begin
                  flen  <= {s_tdata, 8'h00};
                  phase <= PH_LENL;
                end
                PH_LENL: begin
                  flen       <= {flen[15:8], s_tdata};
                  pc         <= '0;
                  frame_rssi <= '0;
                  epc_buf    <= '0;
                  if ({flen[15:8], s_tdata} <= 16'd4) begin
                    // The frame ends inside its own header.
                    phase      <= PH_SOF1;
                    pos        <= '0;
                    res_status <= rfid_dedup_pkg::STATUS_MALFORMED;
                    state      <= ST_EMIT;
                  end else begin
                    pos   <= 16'd4;
                    phase <= PH_BODY;
                  end
                end
                PH_BODY: begin
                  if (pos == 16'd5) begin
                    pc[15:8] <= s_tdata;
                  end else if (pos == 16'd6) begin
                    pc[7:0] <= s_tdata;
                  end else if (pos >= 16'd7) begin
                    if (off < {10'd0, elen}) begin
                      for (int k = 0; k < rfid_dedup_pkg::EPC_BYTES; k++) begin
                        if (off == 16'(k)) begin
                          epc_buf[k] <= s_tdata;
                        end
                      end
                    end else if (off == {10'd0, elen}) begin
                      frame_rssi[15:8] <= s_tdata;
                    end else if (off == {10'd0, elen} + 16'd1) begin
                      frame_rssi[7:0] <= s_tdata;
                    end
                  end
                  if ({1'b0, pos} + 17'd1 >= {1'b0, flen}) begin
                    phase <= PH_SOF1;
                    pos   <= '0;
                    state <= ST_FIN;
                  end else begin
                    pos <= pos + 16'd1;
                  end
                end
                default: begin
                  phase <= PH_SOF1;
                end
              endcase
            end
          end
        end
        ST_FIN: begin
          // A frame too short for its RSSI, or an EPC too long, is malformed.
          if (({1'b0, flen} < 17'd9 + {11'd0, elen}) ||
              (elen > 6'(rfid_dedup_pkg::EPC_BYTES))) begin
            res_status <= rfid_dedup_pkg::STATUS_MALFORMED;
            state      <= ST_EMIT;
          end else begin
            rd_idx  <= '0;
            cmp_vld <= 1'b0;
            state   <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          // Reads are issued one row a cycle; the compare sees each row in the cycle after its read.
          cmp_vld <= rd_idx < entry_count;
          cmp_idx <= rd_idx[5:0];
          if (rd_idx < entry_count) begin
            rd_idx <= rd_idx + 7'd1;
          end
          if (hit || miss_done) begin
            state <= ST_EMIT;
            if (hit) begin
              res_status <= rfid_dedup_pkg::STATUS_UPDATED;
            end else if (add_ok) begin
              res_status  <= rfid_dedup_pkg::STATUS_ADDED;
              entry_count <= entry_count + 7'd1;
            end else begin
              res_status <= rfid_dedup_pkg::STATUS_FULL;
            end
            res_slot <= cand_idx;
            res_cnt  <= new_cnt;
            res_rssi <= new_rssi;
            if (mem_we && better) begin
              best_entry <= cand_idx;
              best_cnt   <= new_cnt;
              best_rssi  <= new_rssi;
            end
          end
        end
        ST_EMIT: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  rfid_dedup_pkg::result_t res;
  logic drop;

  always_comb begin
    drop          = (res_status == rfid_dedup_pkg::STATUS_FULL) ||
                    (res_status == rfid_dedup_pkg::STATUS_MALFORMED);
    res.status    = res_status;
    res.slot      = drop ? 6'd0 : res_slot;
    res.tag_count = drop ? 16'd0 : res_cnt;
    res.tag_rssi  = drop ? 16'sd0 : $signed(res_rssi);
    res.entries   = entry_count;
    res.best_slot = best_entry;
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {3'd0, res};
    end
  end

endmodule

`default_nettype wire

@@ src/rfid_dedup_checker.sv @@
`default_nettype none

module rfid_dedup_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata
);

  logic [1:0] status;
  assign status = m_tdata[1:0];

  // A result waiting at the output must stay until taken.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  // Dropped and malformed frames report no tag fields.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == rfid_dedup_pkg::STATUS_FULL ||
                 status == rfid_dedup_pkg::STATUS_MALFORMED)
    |-> m_tdata[39:2] == '0)
    else $error("dropped frame carries tag fields");

  // The table never holds more than its depth, and the best entry is occupied.
  a_entries: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[46:40] <= 7'(rfid_dedup_pkg::TABLE_DEPTH) &&
                 (m_tdata[46:40] == 7'd0 ? m_tdata[52:47] == 6'd0
                                         : {1'b0, m_tdata[52:47]} < m_tdata[46:40]))
    else $error("entry count or best slot out of range");

  // A new tag starts with a count of one.
  a_new_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status == rfid_dedup_pkg::STATUS_ADDED |-> m_tdata[23:8] == 16'd1)
    else $error("new tag without a count of one");

endmodule

bind rfid_tag_inventory_dedup rfid_dedup_checker u_rfid_dedup_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/rfid_tag_inventory_dedup_test.sv @@
`timescale 1ns / 1ps

module rfid_tag_inventory_dedup_test;

  localparam int CYCLE_LIMIT = 2000000;
  // A frame end scans every occupied row, so the block may still be busy this long.
  localparam int SETTLE_CYCLES = rfid_dedup_pkg::TABLE_DEPTH + 20;
  localparam int DEPTH = rfid_dedup_pkg::TABLE_DEPTH;
  localparam int EPC_N = rfid_dedup_pkg::EPC_BYTES;

  typedef enum logic [2:0] {HUNT_A5, HUNT_5A, LEN_HI, LEN_LO, BODY} parse_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx;
  } reader_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  rfid_tag_inventory_dedup uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reader_beat_t                  pending_beats[$];
  rfid_dedup_pkg::result_t       expected_results[$];
  int           errors = 0;
  int           cycle = 0;
  int           beats_sent = 0;
  int           hold_left = 0;
  bit           hold_done = 0;

  // Shadow of the inventory: parser registers, the tag table and the capacity.
  logic [6:0]           shadow_capacity = 7'd64;
  parse_e               ph = HUNT_A5;
  int unsigned          byte_pos, frame_len, pc_word;
  logic [15:0]          frame_rssi;
  rfid_dedup_pkg::epc_t epc_buf;
  rfid_dedup_pkg::epc_t tag_epc [DEPTH];
  logic signed [15:0]   tag_rssi [DEPTH];
  logic [15:0]          tag_cnt [DEPTH];
  int unsigned          n_entries, best_idx;

  // A small pool of known tags so that repeated sightings are common.
  logic [7:0] tag_pool [16][EPC_N];

  function automatic void clear_inventory();
    ph = HUNT_A5;
    byte_pos = 0;
    frame_len = 0;
    pc_word = 0;
    frame_rssi = '0;
    epc_buf = '0;
    n_entries = 0;
    best_idx = 0;
  endfunction

  function automatic void pick_best();
    best_idx = 0;
    for (int i = 1; i < n_entries; i++)
      if (tag_cnt[i] > tag_cnt[best_idx] ||
          (tag_cnt[i] == tag_cnt[best_idx] && tag_rssi[i] > tag_rssi[best_idx]))
        best_idx = i;
  endfunction

  function automatic rfid_dedup_pkg::result_t frame_outcome(logic [1:0] st,
                                                            int unsigned sl);
    rfid_dedup_pkg::result_t r;
    r = '0;
    r.status = st;
    if (st == rfid_dedup_pkg::STATUS_UPDATED || st == rfid_dedup_pkg::STATUS_ADDED) begin
      r.slot = sl[rfid_dedup_pkg::IDX_W-1:0];
      r.tag_count = tag_cnt[sl];
      r.tag_rssi = tag_rssi[sl];
    end
    r.entries = n_entries[rfid_dedup_pkg::CNT_W-1:0];
    r.best_slot = best_idx[rfid_dedup_pkg::IDX_W-1:0];
    return r;
  endfunction

  // Frame end: look the padded EPC up, then update, add, drop or reject.
  function automatic rfid_dedup_pkg::result_t close_frame();
    int unsigned elen, room;
    elen = ((pc_word >> 11) & 32'h1F) * 2;
    room = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    if (frame_len < 9 + elen || elen > EPC_N)
      return frame_outcome(rfid_dedup_pkg::STATUS_MALFORMED, 0);
    for (int i = 0; i < n_entries; i++) begin
      if (tag_epc[i] == epc_buf) begin
        if ($signed(frame_rssi) > tag_rssi[i]) tag_rssi[i] = frame_rssi;
        if (tag_cnt[i] != 16'hFFFF) tag_cnt[i] = tag_cnt[i] + 16'd1;
        pick_best();
        return frame_outcome(rfid_dedup_pkg::STATUS_UPDATED, i);
      end
    end
    if (n_entries < room) begin
      tag_epc[n_entries] = epc_buf;
      tag_rssi[n_entries] = frame_rssi;
      tag_cnt[n_entries] = 16'd1;
      n_entries++;
      pick_best();
      return frame_outcome(rfid_dedup_pkg::STATUS_ADDED, n_entries - 1);
    end
    return frame_outcome(rfid_dedup_pkg::STATUS_FULL, 0);
  endfunction

  // Advances the shadow by one accepted beat and queues any result it causes.
  function automatic void absorb_beat(logic op, logic [7:0] b);
    int unsigned p, elen;
    if (op == rfid_dedup_pkg::OP_CLEAR) begin
      clear_inventory();
      return;
    end
    case (ph)
      HUNT_A5: begin
        if (b == rfid_dedup_pkg::SOF_FIRST) ph = HUNT_5A;
        return;
      end
      HUNT_5A: begin
        if (b == rfid_dedup_pkg::SOF_SECOND) ph = LEN_HI;
        else if (b != rfid_dedup_pkg::SOF_FIRST) ph = HUNT_A5;
        return;
      end
      LEN_HI: begin
        frame_len = b << 8;
        ph = LEN_LO;
        return;
      end
      LEN_LO: begin
        frame_len = frame_len | b;
        pc_word = 0;
        frame_rssi = '0;
        epc_buf = '0;
        byte_pos = 4;
        if (frame_len <= 4) begin
          ph = HUNT_A5;
          byte_pos = 0;
          expected_results.push_back(frame_outcome(rfid_dedup_pkg::STATUS_MALFORMED, 0));
          return;
        end
        ph = BODY;
        return;
      end
      default: ;
    endcase
    p = byte_pos;
    if (p == 5) pc_word = (pc_word & 32'hFF) | (b << 8);
    else if (p == 6) pc_word = (pc_word & 32'hFF00) | b;
    else if (p >= 7) begin
      elen = ((pc_word >> 11) & 32'h1F) * 2;
      if (p < 7 + elen) begin
        if (p - 7 < EPC_N) epc_buf[p - 7] = b;
      end else if (p == 7 + elen) frame_rssi[15:8] = b;
      else if (p == 8 + elen) frame_rssi[7:0] = b;
    end
    if (p + 1 >= frame_len) begin
      ph = HUNT_A5;
      byte_pos = 0;
      expected_results.push_back(close_frame());
      return;
    end
    byte_pos = p + 1;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    reader_beat_t t;
    t.op = rfid_dedup_pkg::OP_BYTE;
    t.rx = b;
    pending_beats.push_back(t);
  endfunction

  // Queues one frame. epc_field is PC[15:11]; tag < 0 gives fresh random EPC bytes.
  // len_adj shifts the declared length away from the natural one, so a negative value
  // cuts the frame short. It carries as many bytes as it declares, at least four.
  function automatic void push_frame(int epc_field, int tag, logic [15:0] rssi, int trail,
                                     int len_adj);
    int elen, total, sent;
    logic [15:0] flen;
    logic [7:0] b;
    elen = epc_field * 2;
    total = 9 + elen + trail + len_adj;
    if (total < 0) total = 0;
    flen = total[15:0];
    push_byte(rfid_dedup_pkg::SOF_FIRST);
    push_byte(rfid_dedup_pkg::SOF_SECOND);
    push_byte(flen[15:8]);
    push_byte(flen[7:0]);
    sent = 4;
    for (int p = 4; p < total; p++) begin
      if (p == 5) b = {epc_field[4:0], 3'($urandom_range(7))};
      else if (p >= 7 && p < 7 + elen)
        b = (tag >= 0 && p - 7 < EPC_N) ? tag_pool[tag][p - 7] : 8'($urandom);
      else if (p == 7 + elen) b = rssi[15:8];
      else if (p == 8 + elen) b = rssi[7:0];
      else b = 8'($urandom);
      push_byte(b);
    end
  endfunction

  function automatic void push_clear();
    reader_beat_t t;
    t.op = rfid_dedup_pkg::OP_CLEAR;
    t.rx = 8'($urandom);
    pending_beats.push_back(t);
  endfunction

  // Mostly well-formed frames from the tag pool, with broken frames and noise mixed in.
  function automatic void push_random_traffic(int beats);
    int target, kind, fld;
    target = pending_beats.size() + beats;
    while (pending_beats.size() < target) begin
      kind = $urandom_range(99);
      fld = $urandom_range(6);
      if (kind < 60)
        push_frame(fld, $urandom_range(15), 16'($urandom), $urandom_range(3), 0);
      else if (kind < 80)
        push_frame(fld, -1, 16'($urandom), $urandom_range(2), 0);
      else if (kind < 85)
        push_frame(fld, $urandom_range(15), 16'($urandom), 0, -($urandom_range(1, 3)));
      else if (kind < 89)
        push_frame($urandom_range(7, 31), -1, 16'($urandom), $urandom_range(2), 0);
      else if (kind < 92)
        push_frame(0, -1, '0, 0, -($urandom_range(5, 9)));
      else if (kind < 98)
        for (int k = $urandom_range(1, 5); k > 0; k--) push_byte(8'($urandom));
      else
        push_clear();
    end
  endfunction

  // The driver offers beats from the pending queue and feeds each accepted beat to
  // the shadow. It idles at random, except for a stretch early in the run.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_beat(s_tuser, s_tdata);
        beats_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() > 0 &&
            ((beats_sent >= 300 && beats_sent < 600) || $urandom_range(99) >= 27)) begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_beats[0].op;
          s_tdata <= pending_beats[0].rx;
          void'(pending_beats.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long back-pressure episode while the driver keeps offering beats, so that the
  // block's result path fills and it stops taking input.
  always @(posedge clk) begin
    if (!rst && !hold_done && beats_sent >= 800) begin
      hold_left <= 3000;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // The monitor checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    rfid_dedup_pkg::result_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(rfid_dedup_pkg::result_t)-1:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result beat %h", m_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            errors++;
          end
          if (got.tag_count !== want.tag_count) begin
            $error("tag_count: expected %0d, got %0d", want.tag_count, got.tag_count);
            errors++;
          end
          if (got.tag_rssi !== want.tag_rssi) begin
            $error("tag_rssi: expected %0d, got %0d", want.tag_rssi, got.tag_rssi);
            errors++;
          end
          if (got.entries !== want.entries) begin
            $error("entries: expected %0d, got %0d", want.entries, got.entries);
            errors++;
          end
          if (got.best_slot !== want.best_slot) begin
            $error("best_slot: expected %0d, got %0d", want.best_slot, got.best_slot);
            errors++;
          end
          if (m_tdata[55:$bits(rfid_dedup_pkg::result_t)] !== '0) begin
            $error("zero fill: expected 0, got %h",
                   m_tdata[55:$bits(rfid_dedup_pkg::result_t)]);
            errors++;
          end
        end
      end
      if (hold_left > 0) m_tready <= 1'b0;
      else m_tready <= (beats_sent >= 300 && beats_sent < 600) || $urandom_range(99) >= 27;
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Waits until every beat is taken and every result seen, then lets a frame end
  // that is still scanning the table run out before the capacity changes.
  task automatic drain();
    while (pending_beats.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [6:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_capacity = cap;
    @(posedge clk);
  endtask

  initial begin
    logic [6:0] caps [6];
    caps = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64};
    clear_inventory();
    for (int i = 0; i < 16; i++)
      for (int k = 0; k < EPC_N; k++)
        tag_pool[i][k] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_capacity(caps[0]);

    // Directed opening: header-only lengths, a short frame, a repeated first start
    // byte, the largest legal EPC, an oversized EPC field, extreme RSSI values,
    // a long frame with trailing bytes, an empty EPC and a clear.
    push_frame(0, -1, '0, 0, -9);
    push_frame(0, -1, '0, 0, -5);
    push_frame(0, -1, '0, 0, -4);
    push_byte(8'h00);
    push_byte(rfid_dedup_pkg::SOF_FIRST);
    push_frame(6, 0, 16'h7FFF, 0, 0);
    push_frame(6, 0, 16'h8000, 2, 0);
    push_frame(6, 1, 16'h8000, 0, -1);
    push_frame(31, -1, 16'h0123, 0, 0);
    push_frame(0, -1, 16'hFFFF, 0, 0);
    push_frame(1, -1, 16'hFFFF, 290, 0);
    push_byte(8'hFF);
    push_clear();
    push_frame(3, 2, 16'hFF38, 1, 0);
    drain();

    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      if (ph_i > 0) set_capacity(caps[ph_i]);
      push_random_traffic(255);
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
